FILE: design/dlts_pkg.sv
package dlts_pkg;

  localparam int CountW = 13;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GUARDS_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FB_LOW_BOUND  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FB_HIGH_BOUND = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_JUMP_BUDGET   = 2'd3;

  localparam logic [31:0] FB_LOW_RESET  = 32'h8040_0000;
  localparam logic [31:0] FB_HIGH_RESET = 32'h8080_0000;
  localparam logic [7:0]  BUDGET_RESET  = 8'd64;

  // opcodes
  localparam logic [7:0] OP_SKIP16   = 8'hBE;
  localparam logic [7:0] OP_END_A    = 8'hB8;
  localparam logic [7:0] OP_END_B    = 8'hDF;
  localparam logic [7:0] OP_DL       = 8'hDE;
  localparam logic [7:0] OP_DL_ALT   = 8'h06;
  localparam logic [7:0] OP_SET_CIMG = 8'hFF;

  localparam logic [31:0] DL_ALT_MASK = 32'h00FE_FFFF;
  localparam logic [7:0]  KSEG_TOP    = 8'h80;
  localparam logic [26:0] MEM_LIMIT   = 27'h080_0000;
  localparam logic [2:0]  FMT_MAX     = 3'd4;
  localparam logic [CountW-1:0] COUNT_MAX = 13'h1FFF;

  typedef struct packed {
    logic        guards_enable;
    logic [31:0] fb_low_bound;
    logic [31:0] fb_high_bound;
    logic [7:0]  jump_budget;
  } dlts_cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] start_addr;
    logic [31:0] word_hi;
    logic [31:0] word_lo;
  } dlts_item_t;

  typedef struct packed {
    logic [31:0]       addr;
    logic [CountW-1:0] seen;
    logic [CountW-1:0] killed;
    logic [CountW-1:0] passed;
    logic [7:0]        jump_credit;
    logic [7:0]        jumps_taken;
    logic              active;
  } dlts_walk_t;

  typedef struct packed {
    logic [31:0]       fetch_addr;
    logic              rewrite_valid;
    logic [31:0]       rewrite_word;
    logic              walk_done;
    logic [CountW-1:0] images_seen;
    logic [CountW-1:0] images_killed;
    logic [CountW-1:0] images_passed;
    logic [7:0]        jump_count;
    logic [4:0]        stack_level;
  } dlts_result_t;

  function automatic logic past_mem(input logic [31:0] a);
    return ({1'b0, a[25:0]} + 27'd8) > MEM_LIMIT;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v < COUNT_MAX) ? v + 1'b1 : COUNT_MAX;
  endfunction

endpackage

FILE: design/dlts_if.sv
interface dlts_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] start_addr;
  logic [31:0] word_hi;
  logic [31:0] word_lo;

  modport source (output valid, cmd, start_addr, word_hi, word_lo, input ready);
  modport sink   (input valid, cmd, start_addr, word_hi, word_lo, output ready);
endinterface

interface dlts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_addr;
  logic        rewrite_valid;
  logic [31:0] rewrite_word;
  logic        walk_done;
  logic [12:0] images_seen;
  logic [12:0] images_killed;
  logic [12:0] images_passed;
  logic [7:0]  jump_count;
  logic [4:0]  stack_level;

  modport source (output valid, fetch_addr, rewrite_valid, rewrite_word, walk_done,
                  images_seen, images_killed, images_passed, jump_count, stack_level,
                  input ready);
  modport sink   (input valid, fetch_addr, rewrite_valid, rewrite_word, walk_done,
                  images_seen, images_killed, images_passed, jump_count, stack_level,
                  output ready);
endinterface

FILE: design/dlts_stack.sv
module dlts_stack #(
  parameter int STACK_DEPTH = 16,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_idx,
  input  logic [31:0]   wr_data,
  input  logic [SW-1:0] rd_idx,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // read is for the top entry of the next cycle, so a push to it bypasses
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == rd_idx)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dlts_step.sv
module dlts_step #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_COMMANDS = 4096,
  parameter int PW = 5,
  parameter int SW = 4,
  parameter int CW = 13
) (
  input  dlts_pkg::dlts_cfg_t    cfg_i,
  input  dlts_pkg::dlts_item_t   item_i,
  input  dlts_pkg::dlts_walk_t   walk_i,
  input  logic [PW-1:0]          sp_i,
  input  logic [CW-1:0]          cnt_i,
  input  logic [31:0]            top_i,
  output dlts_pkg::dlts_walk_t   walk_o,
  output logic [PW-1:0]          sp_o,
  output logic [CW-1:0]          cnt_o,
  output logic                   push_o,
  output logic [SW-1:0]          push_idx_o,
  output logic [31:0]            push_data_o,
  output dlts_pkg::dlts_result_t res_o
);

  logic [7:0]  op;
  logic        is_dl;
  logic [31:0] img;
  logic [31:0] start_a;
  logic        rw;
  logic        done;

  assign op      = item_i.word_hi[31:24];
  assign is_dl   = ((op == dlts_pkg::OP_DL_ALT) &&
                    ((item_i.word_hi & dlts_pkg::DL_ALT_MASK) == 32'd0)) ||
                   (op == dlts_pkg::OP_DL);
  assign img     = {dlts_pkg::KSEG_TOP, item_i.word_lo[23:0]};
  assign start_a = {6'b100000, item_i.start_addr[25:0]};

  assign push_idx_o  = sp_i[SW-1:0];
  assign push_data_o = walk_i.addr + 32'd8;

  always_comb begin
    walk_o = walk_i;
    sp_o   = sp_i;
    cnt_o  = cnt_i;
    push_o = 1'b0;
    rw     = 1'b0;
    done   = 1'b0;
    if (!item_i.cmd) begin
      sp_o               = '0;
      cnt_o              = '0;
      walk_o.jump_credit = cfg_i.jump_budget;
      walk_o.jumps_taken = '0;
      walk_o.seen        = '0;
      walk_o.killed      = '0;
      walk_o.passed      = '0;
      if (!cfg_i.guards_enable || (item_i.start_addr == 32'd0)) begin
        walk_o.addr   = '0;
        walk_o.active = 1'b0;
        done          = 1'b1;
      end else begin
        walk_o.addr   = start_a;
        walk_o.active = !dlts_pkg::past_mem(start_a);
        done          = dlts_pkg::past_mem(start_a);
      end
    end else if (!walk_i.active) begin
      done = 1'b1;
    end else begin
      cnt_o = CW'(cnt_i + 1'b1);
      if (op == dlts_pkg::OP_SKIP16) begin
        walk_o.addr = walk_i.addr + 32'd16;
      end else if ((op == dlts_pkg::OP_END_A) || (op == dlts_pkg::OP_END_B)) begin
        if (sp_i != '0) begin
          sp_o        = PW'(sp_i - 1'b1);
          walk_o.addr = top_i;
        end else begin
          done = 1'b1;
        end
      end else begin
        if (op == dlts_pkg::OP_SET_CIMG) begin
          walk_o.seen = dlts_pkg::sat_inc(walk_i.seen);
          if ((item_i.word_hi[23:21] <= dlts_pkg::FMT_MAX) && (item_i.word_lo != 32'd0)) begin
            if ((img < cfg_i.fb_low_bound) || (img >= cfg_i.fb_high_bound)) begin
              rw            = 1'b1;
              walk_o.killed = dlts_pkg::sat_inc(walk_i.killed);
            end else begin
              walk_o.passed = dlts_pkg::sat_inc(walk_i.passed);
            end
          end
        end
        if (is_dl && (walk_i.jump_credit != 8'd0)) begin
          // branch flag zero means call: push the return address if room
          if ((item_i.word_hi[23:16] == 8'd0) && (sp_i < PW'(STACK_DEPTH))) begin
            push_o = 1'b1;
            sp_o   = PW'(sp_i + 1'b1);
          end
          walk_o.addr        = {dlts_pkg::KSEG_TOP, item_i.word_lo[23:3], 3'b000};
          walk_o.jump_credit = walk_i.jump_credit - 8'd1;
          walk_o.jumps_taken = walk_i.jumps_taken + 8'd1;
        end else begin
          walk_o.addr = walk_i.addr + 32'd8;
        end
      end
      if ((cnt_o >= CW'(MAX_COMMANDS)) || dlts_pkg::past_mem(walk_o.addr)) begin
        done = 1'b1;
      end
      if (done) begin
        walk_o.active = 1'b0;
      end
    end
  end

  always_comb begin
    res_o.fetch_addr    = walk_o.addr;
    res_o.rewrite_valid = rw;
    res_o.rewrite_word  = rw ? {8'h00, item_i.word_hi[23:0]} : 32'd0;
    res_o.walk_done     = done;
    res_o.images_seen   = walk_o.seen;
    res_o.images_killed = walk_o.killed;
    res_o.images_passed = walk_o.passed;
    res_o.jump_count    = walk_o.jumps_taken;
    res_o.stack_level   = 5'(sp_o);
  end

endmodule

FILE: design/display_list_target_sanitizer.sv
// Display list colour-image target sanitizer.
// in_ch carries one word per item: cmd 0 starts a walk at start_addr, cmd 1
// carries the two command words read at the last reported fetch_addr.
// out_ch returns exactly one result word per input word: the next fetch
// address, an optional rewrite of the first command word (opcode byte
// cleared), walk_done on the last result of a walk, and the running counts.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_data). The user
// must write it only while no word is in flight; it is not enforced here.
// The accepting edge loads the input register and the edge on which that
// word advances loads one pass of next-address logic into the result
// register, which drives out_ch.
// Throughput is one word per cycle unless out_ch stalls; the return
// stack is a small memory with a registered read of the entry that the next
// end command would pop. A stalled out_ch holds its result; in_ch keeps
// accepting until the input register is also full, then drops ready.
// Reset clears both valid flags, the walk state (idle, all counts zero) and
// loads the register defaults; return stack contents are not cleared.
module display_list_target_sanitizer #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_COMMANDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dlts_in_if.sink                       in_ch,
  dlts_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [dlts_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [31:0]                   cfg_data
);

  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(MAX_COMMANDS + 1);

  dlts_pkg::dlts_cfg_t    cfg_r;
  dlts_pkg::dlts_item_t   item_r;
  dlts_pkg::dlts_walk_t   walk_r;
  dlts_pkg::dlts_walk_t   walk_nxt;
  dlts_pkg::dlts_result_t out_r;
  dlts_pkg::dlts_result_t res;
  logic                   in_valid_r;
  logic                   out_valid_r;
  logic [PW-1:0]          sp_r;
  logic [PW-1:0]          sp_nxt;
  logic [PW-1:0]          sp_next_cycle;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic                   advance;
  logic                   push;
  logic [SW-1:0]          push_idx;
  logic [31:0]            push_data;
  logic [31:0]            top;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  dlts_step #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_COMMANDS(MAX_COMMANDS),
    .PW          (PW),
    .SW          (SW),
    .CW          (CW)
  ) u_step (
    .cfg_i      (cfg_r),
    .item_i     (item_r),
    .walk_i     (walk_r),
    .sp_i       (sp_r),
    .cnt_i      (cnt_r),
    .top_i      (top),
    .walk_o     (walk_nxt),
    .sp_o       (sp_nxt),
    .cnt_o      (cnt_nxt),
    .push_o     (push),
    .push_idx_o (push_idx),
    .push_data_o(push_data),
    .res_o      (res)
  );

  // prefetch the entry below the stack pointer of the coming cycle
  assign sp_next_cycle = advance ? sp_nxt : sp_r;

  dlts_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .SW         (SW)
  ) u_stack (
    .clk    (clk),
    .wr_en  (advance && push),
    .wr_idx (push_idx),
    .wr_data(push_data),
    .rd_idx (SW'(sp_next_cycle - 1'b1)),
    .rd_data(top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      walk_r      <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      cfg_r.guards_enable <= 1'b0;
      cfg_r.fb_low_bound  <= dlts_pkg::FB_LOW_RESET;
      cfg_r.fb_high_bound <= dlts_pkg::FB_HIGH_RESET;
      cfg_r.jump_budget   <= dlts_pkg::BUDGET_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        walk_r      <= walk_nxt;
        sp_r        <= sp_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          dlts_pkg::REG_GUARDS_ENABLE: cfg_r.guards_enable <= cfg_data[0];
          dlts_pkg::REG_FB_LOW_BOUND:  cfg_r.fb_low_bound  <= cfg_data;
          dlts_pkg::REG_FB_HIGH_BOUND: cfg_r.fb_high_bound <= cfg_data;
          dlts_pkg::REG_JUMP_BUDGET:   cfg_r.jump_budget   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.cmd        <= in_ch.cmd;
      item_r.start_addr <= in_ch.start_addr;
      item_r.word_hi    <= in_ch.word_hi;
      item_r.word_lo    <= in_ch.word_lo;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fetch_addr    = out_r.fetch_addr;
  assign out_ch.rewrite_valid = out_r.rewrite_valid;
  assign out_ch.rewrite_word  = out_r.rewrite_word;
  assign out_ch.walk_done     = out_r.walk_done;
  assign out_ch.images_seen   = out_r.images_seen;
  assign out_ch.images_killed = out_r.images_killed;
  assign out_ch.images_passed = out_r.images_passed;
  assign out_ch.jump_count    = out_r.jump_count;
  assign out_ch.stack_level   = out_r.stack_level;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(STACK_DEPTH))
    else $error("return stack pointer beyond depth");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r.killed <= walk_r.seen) && (walk_r.passed <= walk_r.seen))
    else $error("killed or passed count exceeds seen count");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_r.cmd && !walk_r.active |=> (sp_r == $past(sp_r)) &&
      (walk_r.addr == $past(walk_r.addr)))
    else $error("idle command changed walk state");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word produced no result");

endmodule
